### design/rbu_pkg.sv
// Shared types and constants of the record block/unblock converter.
package rbu_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int MAX_LEN     = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]  RESET_RECORD_LENGTH = LEN_W'(MAX_LEN);
    localparam logic [BYTE_W-1:0] RESET_NEWLINE_CHAR  = BYTE_W'(10);
    localparam logic [BYTE_W-1:0] RESET_SPACE_CHAR    = BYTE_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_UNBLOCK  = CFG_IDX_W'(0),
        REG_RECORD_LENGTH = CFG_IDX_W'(1),
        REG_NEWLINE_CHAR  = CFG_IDX_W'(2),
        REG_SPACE_CHAR    = CFG_IDX_W'(3)
    } rbu_reg_t;

    // Active configuration, with the record length already clamped to 1..64.
    typedef struct packed {
        logic              mode_unblock;
        logic [LEN_W-1:0]  rec_len;
        logic [BYTE_W-1:0] newline_char;
        logic [BYTE_W-1:0] space_char;
    } rbu_cfg_t;

    // One classified byte: an optional newline, a run of spaces, an optional data byte.
    typedef struct packed {
        logic               has_nl;
        logic [LEN_W-1:0]   spaces;
        logic               has_byte;
        logic [BYTE_W-1:0]  nl_byte;
        logic [BYTE_W-1:0]  sp_byte;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } rbu_cmd_t;

endpackage

### design/rbu_byte_if.sv
// Byte stream channel carrying one input byte per beat.
interface rbu_byte_if;
    import rbu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### design/rbu_result_if.sv
// Result channel carrying one converted byte per beat.
interface rbu_result_if;
    import rbu_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               run_last;
    logic [COUNT_W-1:0] truncated_count;

    modport source (output valid, output out_byte, output run_last, output truncated_count,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input truncated_count,
                    output ready);
endinterface

### design/record_block_unblock_core.sv
// Top level of the record block/unblock converter.
//
// The block converts a byte stream between newline-terminated lines and
// fixed-length records. Bytes arrive on the bytes channel, one per beat, and
// converted bytes leave on the results channel, one per beat. Each result
// beat carries run_last, set on the final beat caused by one input byte, and
// the saturating count of truncated records at that point. An input byte
// may cause no beat at all, or a run of up to 64 beats (padding spaces, or
// held-back spaces followed by the byte).
//
// The front end classifies each byte in the cycle it is accepted and puts
// a command into a two-entry queue. The back end takes one command, loads
// it, and then emits one result beat per cycle while the receiver takes
// them; it takes the next command only once the run is done. Each byte's
// first result beat passes through the queue, back end and output register.
//
// Reset clears the stream state, the queue and the output register, and loads
// the default configuration. When the receiver stalls, the output beat holds,
// the queue fills, and bytes ready drops once the queue is full. The user must
// write registers on the plain write port while the block is idle; unchecked.
module record_block_unblock_core
    import rbu_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rbu_byte_if.sink              bytes,
    rbu_result_if.source          results
);

    logic              mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] nl_reg, nl_next;
    logic [BYTE_W-1:0] sp_reg, sp_next;
    logic              stream_clear;

    rbu_cfg_t          cfg;
    logic              accept;
    logic              cmd_push;
    rbu_cmd_t          push_cmd;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    rbu_cmd_t          head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            len_reg  <= RESET_RECORD_LENGTH;
            nl_reg   <= RESET_NEWLINE_CHAR;
            sp_reg   <= RESET_SPACE_CHAR;
        end
        else
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            nl_reg   <= nl_next;
            sp_reg   <= sp_next;
        end
    end

    // Register writes; a write to the mode register also starts a new stream.
    always_comb
    begin
        mode_next    = mode_reg;
        len_next     = len_reg;
        nl_next      = nl_reg;
        sp_next      = sp_reg;
        stream_clear = 1'b0;
        if (cfg_we)
        begin
            case (rbu_reg_t'(cfg_index))
                REG_MODE_UNBLOCK:
                begin
                    mode_next    = cfg_data[0];
                    stream_clear = 1'b1;
                end
                REG_RECORD_LENGTH: len_next = cfg_data[LEN_W-1:0];
                REG_NEWLINE_CHAR:  nl_next  = cfg_data[BYTE_W-1:0];
                REG_SPACE_CHAR:    sp_next  = cfg_data[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    // A length of zero acts as one and anything past 64 acts as 64.
    always_comb
    begin
        cfg.mode_unblock = mode_reg;
        cfg.newline_char = nl_reg;
        cfg.space_char   = sp_reg;
        if (len_reg == '0)
        begin
            cfg.rec_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_LEN))
        begin
            cfg.rec_len = LEN_W'(MAX_LEN);
        end
        else
        begin
            cfg.rec_len = len_reg;
        end
    end

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && !q_full;

    rbu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .stream_clear (stream_clear),
        .accept       (accept),
        .data_byte    (bytes.data_byte),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd)
    );

    rbu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    rbu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_byte  (results.out_byte),
        .out_last  (results.run_last),
        .out_count (results.truncated_count)
    );

endmodule

### design/rbu_front.sv
// Front end: accepts input bytes, tracks column and truncation, issues commands.
module rbu_front
    import rbu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rbu_cfg_t          cfg,
    input  logic              stream_clear,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              cmd_push,
    output rbu_cmd_t          cmd
);

    logic [LEN_W-1:0]   column_reg, column_next;
    logic [LEN_W-1:0]   pending_reg, pending_next;
    logic               truncating_reg, truncating_next;
    logic [COUNT_W-1:0] trunc_count_reg, trunc_count_next;

    logic               col_full;
    logic [LEN_W-1:0]   base_col;
    logic [LEN_W-1:0]   base_pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            pending_reg     <= '0;
            truncating_reg  <= 1'b0;
            trunc_count_reg <= '0;
        end
        else
        begin
            column_reg      <= column_next;
            pending_reg     <= pending_next;
            truncating_reg  <= truncating_next;
            trunc_count_reg <= trunc_count_next;
        end
    end

    always_comb
    begin
        col_full  = (column_reg >= cfg.rec_len);
        base_col  = col_full ? '0 : column_reg;
        base_pend = col_full ? '0 : pending_reg;

        column_next      = column_reg;
        pending_next     = pending_reg;
        truncating_next  = truncating_reg;
        trunc_count_next = trunc_count_reg;

        cmd_push     = 1'b0;
        cmd.has_nl   = 1'b0;
        cmd.spaces   = '0;
        cmd.has_byte = 1'b0;
        cmd.nl_byte  = cfg.newline_char;
        cmd.sp_byte  = cfg.space_char;
        cmd.data     = data_byte;
        cmd.count    = trunc_count_reg;

        if (stream_clear)
        begin
            column_next     = '0;
            pending_next    = '0;
            truncating_next = 1'b0;
        end
        else if (accept)
        begin
            if (!cfg.mode_unblock)
            begin
                if (data_byte == cfg.newline_char)
                begin
                    // Pad the rest of the record; a full record needs nothing.
                    cmd.spaces      = col_full ? '0 : (cfg.rec_len - column_reg);
                    cmd_push        = !col_full;
                    column_next     = '0;
                    truncating_next = 1'b0;
                end
                else if (col_full)
                begin
                    if (!truncating_reg)
                    begin
                        truncating_next = 1'b1;
                        if (trunc_count_reg != '1)
                        begin
                            trunc_count_next = trunc_count_reg + COUNT_W'(1);
                        end
                    end
                end
                else
                begin
                    cmd.has_byte = 1'b1;
                    cmd_push     = 1'b1;
                    column_next  = column_reg + LEN_W'(1);
                end
            end
            else
            begin
                // A byte after a full record first closes that record with a newline.
                cmd.has_nl  = col_full;
                column_next = base_col + LEN_W'(1);
                if (data_byte == cfg.space_char)
                begin
                    pending_next = base_pend + LEN_W'(1);
                    cmd_push     = col_full;
                end
                else
                begin
                    cmd.spaces   = base_pend;
                    cmd.has_byte = 1'b1;
                    cmd_push     = 1'b1;
                    pending_next = '0;
                end
            end
        end
    end

endmodule

### design/rbu_queue.sv
// Small register queue that decouples the front end from the back end.
module rbu_queue
    import rbu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rbu_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output rbu_cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rbu_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_comb
    begin
        full      = (fill_reg == CNT_W'(DEPTH));
        not_empty = (fill_reg != '0);
        head_cmd  = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;

        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

endmodule

### design/rbu_back.sv
// Back end: expands one command into its run of output bytes.
module rbu_back
    import rbu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  rbu_cmd_t           cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               out_last,
    output logic [COUNT_W-1:0] out_count
);

    logic               busy_reg, busy_next;
    logic               nl_pend_reg, nl_pend_next;
    logic [LEN_W-1:0]   spaces_reg, spaces_next;
    logic               byte_pend_reg, byte_pend_next;
    rbu_cmd_t           cur_reg, cur_next;

    logic               ov_reg, ov_next;
    logic [BYTE_W-1:0]  ob_reg, ob_next;
    logic               ol_reg, ol_next;
    logic [COUNT_W-1:0] oc_reg, oc_next;

    logic               advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            nl_pend_reg   <= 1'b0;
            spaces_reg    <= '0;
            byte_pend_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            nl_pend_reg   <= nl_pend_next;
            spaces_reg    <= spaces_next;
            byte_pend_reg <= byte_pend_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
        oc_reg  <= oc_next;
    end

    always_comb
    begin
        advance = !ov_reg || out_ready;
        cmd_pop = !busy_reg && cmd_valid;

        busy_next      = busy_reg;
        nl_pend_next   = nl_pend_reg;
        spaces_next    = spaces_reg;
        byte_pend_next = byte_pend_reg;
        cur_next       = cur_reg;
        ov_next        = ov_reg;
        ob_next        = ob_reg;
        ol_next        = ol_reg;
        oc_next        = oc_reg;

        if (cmd_pop)
        begin
            busy_next      = 1'b1;
            nl_pend_next   = cmd.has_nl;
            spaces_next    = cmd.spaces;
            byte_pend_next = cmd.has_byte;
            cur_next       = cmd;
        end

        if (advance)
        begin
            ov_next = busy_reg;
            if (busy_reg)
            begin
                // Emission order: newline, then spaces, then the data byte.
                if (nl_pend_reg)
                begin
                    ob_next      = cur_reg.nl_byte;
                    nl_pend_next = 1'b0;
                end
                else if (spaces_reg != '0)
                begin
                    ob_next     = cur_reg.sp_byte;
                    spaces_next = spaces_reg - LEN_W'(1);
                end
                else
                begin
                    ob_next        = cur_reg.data;
                    byte_pend_next = 1'b0;
                end
                ol_next   = !(nl_pend_next || (spaces_next != '0) || byte_pend_next);
                oc_next   = cur_reg.count;
                busy_next = !ol_next;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;
    assign out_count = oc_reg;

endmodule

### design/rbu_checker.sv
// Port-level checker for the converter, bound to the top level.
module rbu_checker
    import rbu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [BYTE_W-1:0]  res_byte,
    input logic               res_last,
    input logic [COUNT_W-1:0] res_count
);

    // Nothing is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // A stalled beat keeps its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_byte) && $stable(res_last) && $stable(res_count)))
        else $error("stalled result changed");

    // Inside a run the next beat follows at once and carries the same count.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res_last) |=> (res_valid && $stable(res_count)))
        else $error("run broken or count changed inside a run");

endmodule

bind record_block_unblock_core rbu_checker u_rbu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_byte  (results.out_byte),
    .res_last  (results.run_last),
    .res_count (results.truncated_count)
);

### verif/tb_record_block_unblock_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the record block/unblock converter top level.
module tb_record_block_unblock_core;
    import rbu_pkg::*;

    // The settle time keeps the block quiet before a register write. The tail
    // time covers a full 64-beat run that nobody expected.
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 70;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_DATA_W-1:0] MODE_BLOCK   = CFG_DATA_W'(0);
    localparam logic [CFG_DATA_W-1:0] MODE_UNBLOCK = CFG_DATA_W'(1);

    // Indexes that map to no register; a write to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = CFG_IDX_W'(15);

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               run_last;
        logic [COUNT_W-1:0] count;
    } out_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rbu_byte_if   bytes_ch ();
    rbu_result_if results_ch ();

    record_block_unblock_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (bytes_ch),
        .results   (results_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the converter: configuration as last written, and the
    // stream state that the block carries from byte to byte.
    logic               unblock_mode  = 1'b0;
    logic [LEN_W-1:0]   rec_len       = RESET_RECORD_LENGTH;
    logic [BYTE_W-1:0]  nl_char       = RESET_NEWLINE_CHAR;
    logic [BYTE_W-1:0]  sp_char       = RESET_SPACE_CHAR;
    logic [LEN_W-1:0]   column        = '0;
    logic [LEN_W-1:0]   held_spaces   = '0;
    logic               dropping      = 1'b0;
    logic [COUNT_W-1:0] trunc_records = '0;

    // Converted beats still owed by the block, oldest first.
    out_beat_t converted_q[$];

    bit send_idle_en   = 1'b0;
    bit recv_idle_en   = 1'b0;
    bit idling_allowed = 1'b1;

    int bytes_sent    = 0;
    int beats_checked = 0;
    int cfg_writes    = 0;
    int fail_count    = 0;

    // A length of zero acts as one, and anything past 64 acts as 64.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] r);
        if (r == '0)
            return LEN_W'(1);
        if (r > LEN_W'(MAX_LEN))
            return LEN_W'(MAX_LEN);
        return r;
    endfunction

    // Works out the beats that one accepted byte causes and queues them.
    function automatic void convert_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] run[$];
        logic [LEN_W-1:0]  len;
        out_beat_t         beat;
        int                j;
        len = eff_len(rec_len);
        if (!unblock_mode)
        begin
            if (b == nl_char)
            begin
                // Pad the line out to the record length; nothing if already full.
                for (j = int'(column); j < int'(len); j++)
                    run.push_back(sp_char);
                column   = '0;
                dropping = 1'b0;
            end
            else if (column >= len)
            begin
                // Only the first dropped byte of a line counts as a truncation.
                if (!dropping)
                begin
                    dropping = 1'b1;
                    if (trunc_records != '1)
                        trunc_records++;
                end
            end
            else
            begin
                run.push_back(b);
                column++;
            end
        end
        else
        begin
            // The newline of a full record goes out with the next record's first byte.
            if (column >= len)
            begin
                run.push_back(nl_char);
                column      = '0;
                held_spaces = '0;
            end
            column++;
            if (b == sp_char)
                held_spaces++;
            else
            begin
                repeat (held_spaces) run.push_back(sp_char);
                held_spaces = '0;
                run.push_back(b);
            end
        end
        while (run.size() > MAX_LEN)
            void'(run.pop_back());
        foreach (run[k])
        begin
            beat.out_byte = run[k];
            beat.run_last = (k == run.size() - 1);
            beat.count    = trunc_records;
            converted_q.push_back(beat);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] avoid);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == avoid);
        return b;
    endfunction

    function automatic void flag_beat(input string why, input out_beat_t want,
                                      input out_beat_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s: expected byte %02h last %b count %0d, got byte %02h last %b count %0d",
                     $time, why, want.out_byte, want.run_last, want.count,
                     got.out_byte, got.run_last, got.count);
    endfunction

    // Receiver: ready is pulled low in random bursts while stalls are enabled,
    // and held high otherwise.
    initial
    begin
        int stall_left;
        stall_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                results_ch.ready <= 1'b0;
            end
            else if (recv_idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    // Every result beat taken at an edge is compared with the oldest owed beat.
    always @(posedge clk)
    begin
        out_beat_t got;
        out_beat_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            beats_checked++;
            got.out_byte = results_ch.out_byte;
            got.run_last = results_ch.run_last;
            got.count    = results_ch.truncated_count;
            if (converted_q.size() == 0)
                flag_beat("beat with nothing owed", '0, got);
            else
            begin
                want = converted_q.pop_front();
                if (got !== want)
                    flag_beat("beat mismatch", want, got);
            end
        end
    end

    // Offers one byte, with an occasional gap before it, and waits for the
    // beat. Valid stays high afterwards so back-to-back bytes need no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (send_idle_en && $urandom_range(0, 5) == 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!bytes_ch.ready);
        convert_byte(b);
        bytes_sent++;
    endtask

    // Holds the sender until every owed beat has come, then waits out the
    // settle time.
    task automatic wait_idle();
        bytes_ch.valid <= 1'b0;
        while (converted_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the enable then stays low before the task returns, so
    // it is never dropped and raised within one step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_MODE_UNBLOCK:
            begin
                // Any mode write starts a new stream.
                unblock_mode = data[0];
                column       = '0;
                held_spaces  = '0;
                dropping     = 1'b0;
            end
            REG_RECORD_LENGTH: rec_len = data[LEN_W-1:0];
            REG_NEWLINE_CHAR:  nl_char = data;
            REG_SPACE_CHAR:    sp_char = data;
            default:           ;
        endcase
        @(posedge clk);
    endtask

    // New record length and characters for a stretch of random traffic.
    // Lengths are mostly short; 64 and out-of-range codes come now and then.
    task automatic random_settings();
        logic [CFG_DATA_W-1:0] len_data;
        wait_idle();
        case ($urandom_range(0, 9))
            0:       len_data = CFG_DATA_W'(MAX_LEN);
            1:       len_data = CFG_DATA_W'($urandom_range(MAX_LEN + 1, 255));
            default: len_data = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        cfg_write(REG_RECORD_LENGTH, len_data);
        cfg_write(REG_NEWLINE_CHAR, ($urandom_range(0, 2) == 0) ?
                  CFG_DATA_W'($urandom_range(0, 255)) : RESET_NEWLINE_CHAR);
        cfg_write(REG_SPACE_CHAR, ($urandom_range(0, 2) == 0) ?
                  CFG_DATA_W'($urandom_range(0, 255)) : RESET_SPACE_CHAR);
        // Some stretches run with no idling on one side or both.
        send_idle_en = idling_allowed && ($urandom_range(0, 3) != 0);
        recv_idle_en = idling_allowed && ($urandom_range(0, 3) != 0);
    endtask

    // Reset configuration: block mode, 64-byte records. Short lines, bytes
    // at both ends of the range, and an empty line that pads a whole record.
    task automatic test_block_defaults();
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(nl_char);
        send_byte(nl_char);
    endtask

    // Three-byte records with the line end at 0xFF and padding at 0x00. The
    // old line end and space codes pass as data, and an overlong line is cut
    // and counted once; its line end then makes no beat.
    task automatic test_block_truncation();
        wait_idle();
        cfg_write(REG_RECORD_LENGTH, CFG_DATA_W'(3));
        cfg_write(REG_NEWLINE_CHAR, 8'hFF);
        cfg_write(REG_SPACE_CHAR, 8'h00);
        send_byte(8'h0A);
        send_byte(8'h20);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'h55);
        send_byte(nl_char);
        send_byte(8'h01);
        send_byte(nl_char);
    endtask

    // Length codes of zero and 127 clamp to 1 and 64. Shrinking the length
    // in the middle of a line makes the line already full.
    task automatic test_record_length();
        wait_idle();
        cfg_write(REG_RECORD_LENGTH, 8'h00);
        send_byte(8'h33);
        send_byte(8'h34);
        send_byte(nl_char);
        wait_idle();
        cfg_write(REG_RECORD_LENGTH, 8'hFF);
        send_byte(8'h35);
        send_byte(nl_char);
        wait_idle();
        cfg_write(REG_RECORD_LENGTH, CFG_DATA_W'(5));
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
        cfg_write(REG_RECORD_LENGTH, CFG_DATA_W'(2));
        send_byte(8'h44);
        send_byte(nl_char);
    endtask

    // Unblock mode with four-byte records: held spaces come out before the
    // next non-space byte, trailing spaces vanish, and the newline waits for
    // the next record. A repeated mode write restarts the stream, writes to
    // unmapped indexes do nothing, and a length code of 128 acts as 1.
    task automatic test_unblock_directed();
        wait_idle();
        cfg_write(REG_MODE_UNBLOCK, MODE_UNBLOCK);
        cfg_write(REG_RECORD_LENGTH, CFG_DATA_W'(4));
        cfg_write(REG_NEWLINE_CHAR, RESET_NEWLINE_CHAR);
        cfg_write(REG_SPACE_CHAR, RESET_SPACE_CHAR);
        send_byte(8'h41);
        send_byte(sp_char);
        send_byte(8'h42);
        send_byte(sp_char);
        send_byte(sp_char);
        send_byte(8'h43);
        wait_idle();
        cfg_write(REG_MODE_UNBLOCK, MODE_UNBLOCK);
        send_byte(8'h44);
        wait_idle();
        cfg_write(REG_UNMAPPED_LOW, 8'hFF);
        cfg_write(REG_UNMAPPED_TOP, 8'hFF);
        cfg_write(REG_RECORD_LENGTH, 8'h80);
        send_byte(8'h46);
        send_byte(sp_char);
        send_byte(8'h47);
    endtask

    // Block mode with random lines around the record length, plus some
    // stray bytes that may hold the line end anywhere.
    task automatic test_random_block(input int n_bytes);
        int stop_at;
        int seg_len;
        int line_len;
        stop_at = bytes_sent + n_bytes;
        wait_idle();
        cfg_write(REG_MODE_UNBLOCK, MODE_BLOCK);
        while (bytes_sent < stop_at)
        begin
            random_settings();
            seg_len = int'(eff_len(rec_len));
            repeat ((seg_len > 16) ? 1 : $urandom_range(3, 6))
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
                else
                begin
                    line_len = $urandom_range(0, seg_len + 2);
                    repeat (line_len) send_byte(other_than(nl_char));
                    send_byte(nl_char);
                end
            end
        end
    endtask

    // Unblock mode with whole records of text and trailing spaces, records
    // of spaces that end in one other byte, and partial records that shift
    // the alignment.
    task automatic test_random_unblock(input int n_bytes);
        int stop_at;
        int seg_len;
        int tail;
        stop_at = bytes_sent + n_bytes;
        wait_idle();
        cfg_write(REG_MODE_UNBLOCK, MODE_UNBLOCK);
        while (bytes_sent < stop_at)
        begin
            random_settings();
            seg_len = int'(eff_len(rec_len));
            repeat ((seg_len > 16) ? 1 : $urandom_range(3, 6))
            begin
                case ($urandom_range(0, 7))
                    0:
                        repeat ($urandom_range(1, seg_len)) send_byte(BYTE_W'($urandom));
                    1:
                    begin
                        repeat (seg_len - 1) send_byte(sp_char);
                        send_byte(other_than(sp_char));
                    end
                    default:
                    begin
                        tail = $urandom_range(0, seg_len);
                        repeat (seg_len - tail)
                            send_byte(($urandom_range(0, 3) == 0) ? sp_char
                                                                  : BYTE_W'($urandom));
                        repeat (tail) send_byte(sp_char);
                    end
                endcase
            end
        end
    endtask

    // Last part: both sides run flat out, in each mode.
    task automatic test_streaming();
        wait_idle();
        idling_allowed = 1'b0;
        send_idle_en   = 1'b0;
        recv_idle_en   = 1'b0;
        test_random_block(15);
        test_random_unblock(15);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_MODE_UNBLOCK;
        cfg_data           <= '0;
        bytes_ch.valid     <= 1'b0;
        bytes_ch.data_byte <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_block_defaults();
        test_block_truncation();
        test_record_length();
        test_unblock_directed();
        test_random_block(40);
        test_random_unblock(40);
        test_streaming();

        bytes_ch.valid <= 1'b0;
        while (converted_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in block and unblock modes over %0d register writes;",
                 bytes_sent, cfg_writes);
        $display("checked %0d beats, %0d truncated records, %0d mismatches.",
                 beats_checked, trunc_records, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
